### hdl/msc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// shared widths, controller states and command/status types for the masked
// soft confusion and rmse block
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int SUM_W    = 28;
    localparam int SQ_W     = 37;
    localparam int CNT_W    = 21;
    localparam int FRAC_SH  = 16;
    localparam int NUM_W    = SQ_W + FRAC_SH;
    localparam int ROOT_W   = (NUM_W + 1) / 2;
    localparam int RMSE_W   = 16;
    localparam int CODE_W   = 8;
    localparam int IN_DW    = 16;
    localparam int OUT_DW   = 168;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_SQ_GO,
        ST_SQ_RUN,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic take;
        logic take_last;
        logic div_start;
        logic sqrt_start;
        logic load_totals;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic div_done;
        logic sqrt_done;
    } t_status;

endpackage

### hdl/masked_soft_confusion_rmse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_soft_confusion_rmse
// Streams one frame of pixels and reports soft confusion totals and RMSE.
// Slave channel: one beat per pixel, tdata = predicted and truth codes,
// tuser = region bit, tlast = last pixel of the frame.
// Master channel: exactly one beat per pixel beat, carrying the difference
// pixel; on the beat for the last pixel tlast is set and the four soft sums,
// the region pixel count and the RMSE (8 fraction bits) are valid, otherwise
// those fields are zero.
// Pixels are accepted one per cycle while the output register is free or
// being taken and no frame's totals are in progress; each result but the
// last pixel's appears in the next cycle in an output register, which frees
// as the beat is taken. The last pixel of a frame is followed by the
// bit-serial divider for sum of squares over count, the bit-serial square
// root and the sequencing states, with the slave ready low meanwhile.
// Reset clears all accumulators and empties the output register.
// When the master side stalls, the output beat is held and no new pixel is
// accepted until it is taken.
// ----------------------------------------------------------------------------
module masked_soft_confusion_rmse
    import msc_pkg::*;
#(
    parameter int MAX_PIXELS = 1048576,
    parameter int VALUE_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // predicted [7:0], truth [15:8]
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // region_valid [0]
    input  logic              s_axis_tuser,
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // diff_red [7:0], diff_blue [15:8], sum_false_pos [43:16],
    // sum_false_neg [71:44], sum_true_pos [99:72], sum_true_neg [127:100],
    // rmse_value [143:128], pixels_counted [164:144], zero [167:165]
    output logic [OUT_DW-1:0] m_axis_tdata,
    // totals_valid
    output logic              m_axis_tlast
);

    t_cmd    cmd;
    t_status status;

    logic [CODE_W-1:0] diff_red, diff_blue;
    logic [SUM_W-1:0]  sum_fp, sum_fn, sum_tp, sum_tn;
    logic [RMSE_W-1:0] rmse_value;
    logic [CNT_W-1:0]  pixels_counted;

    msc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    msc_dpath #(
        .MAX_PIXELS (MAX_PIXELS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_region         (s_axis_tuser),
        .i_predicted      (s_axis_tdata[7:0]),
        .i_truth          (s_axis_tdata[15:8]),
        .i_out_ready      (m_axis_tready),
        .o_status         (status),
        .o_out_valid      (m_axis_tvalid),
        .o_totals_valid   (m_axis_tlast),
        .o_diff_red       (diff_red),
        .o_diff_blue      (diff_blue),
        .o_sum_false_pos  (sum_fp),
        .o_sum_false_neg  (sum_fn),
        .o_sum_true_pos   (sum_tp),
        .o_sum_true_neg   (sum_tn),
        .o_rmse_value     (rmse_value),
        .o_pixels_counted (pixels_counted)
    );

    assign m_axis_tdata = {3'b000, pixels_counted, rmse_value, sum_tn, sum_tp,
                           sum_fn, sum_fp, diff_blue, diff_red};

endmodule

### hdl/msc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module msc_div
    import msc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_dividend,
    input  logic [CNT_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [NUM_W-1:0]   o_quotient
);

    localparam int CW = $clog2(NUM_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(NUM_W - 1);

    logic             r_busy, n_busy;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num;
    logic [CNT_W:0]   r_rem, n_rem;
    logic [CNT_W:0]   trial;
    logic             fits;

    always_comb begin
        trial = {r_rem[CNT_W-1:0], r_num[NUM_W-1]};
        fits  = (trial >= {1'b0, i_divisor});
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = LAST_STEP;
            n_num  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = fits ? (trial - {1'b0, i_divisor}) : trial;
            n_num = {r_num[NUM_W-2:0], fits};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_num;

endmodule

### hdl/msc_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_isqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module msc_isqrt
    import msc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int XW = 2 * ROOT_W;
    localparam int CW = $clog2(ROOT_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(ROOT_W - 1);

    logic              r_busy, n_busy;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [XW-1:0]     r_x, n_x;
    logic [ROOT_W+1:0] r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    always_comb begin
        rem_sh = {r_rem[ROOT_W-1:0], r_x[XW-1 -: 2]};
        trial  = {r_root, 2'b01};
        fits   = (rem_sh >= trial);
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = LAST_STEP;
            n_x    = XW'(i_radicand);
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rem  = fits ? (rem_sh - trial) : rem_sh;
            n_root = {r_root[ROOT_W-2:0], fits};
            n_x    = {r_x[XW-3:0], 2'b00};
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_root = r_root;

endmodule

### hdl/msc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_ctrl
// sequencer: pixel accumulation, then divide, root and totals load per frame
// ----------------------------------------------------------------------------
module msc_ctrl
    import msc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   ready;

    assign ready = (r_state == ST_ACC) && i_status.slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC: begin
                if (ready && i_in_valid && i_in_last) begin
                    n_state = ST_DIV_GO;
                end
            end
            ST_DIV_GO:  n_state = ST_DIV_RUN;
            ST_DIV_RUN: begin
                if (i_status.div_done) begin
                    n_state = ST_SQ_GO;
                end
            end
            ST_SQ_GO:   n_state = ST_SQ_RUN;
            ST_SQ_RUN: begin
                if (i_status.sqrt_done) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD:    n_state = ST_ACC;
            default:    n_state = ST_ACC;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_ACC: begin
                o_cmd.take      = ready && i_in_valid;
                o_cmd.take_last = ready && i_in_valid && i_in_last;
            end
            ST_DIV_GO: o_cmd.div_start   = 1'b1;
            ST_SQ_GO:  o_cmd.sqrt_start  = 1'b1;
            ST_LOAD:   o_cmd.load_totals = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

    assign o_in_ready = ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/msc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_dpath
// saturating accumulators, frame snapshot, divide/root units, output register
// ----------------------------------------------------------------------------
module msc_dpath
    import msc_pkg::*;
#(
    parameter int MAX_PIXELS = 1048576,
    parameter int VALUE_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_region,
    input  logic [CODE_W-1:0] i_predicted,
    input  logic [CODE_W-1:0] i_truth,
    input  logic              i_out_ready,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic              o_totals_valid,
    output logic [CODE_W-1:0] o_diff_red,
    output logic [CODE_W-1:0] o_diff_blue,
    output logic [SUM_W-1:0]  o_sum_false_pos,
    output logic [SUM_W-1:0]  o_sum_false_neg,
    output logic [SUM_W-1:0]  o_sum_true_pos,
    output logic [SUM_W-1:0]  o_sum_true_neg,
    output logic [RMSE_W-1:0] o_rmse_value,
    output logic [CNT_W-1:0]  o_pixels_counted
);

    localparam int PW = (VALUE_BITS < CODE_W) ? VALUE_BITS : CODE_W;
    localparam logic [63:0] CODE_MAX64 = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [63:0] SUM_FRAME  = CODE_MAX64 * 64'(MAX_PIXELS);
    localparam logic [63:0] SQ_FRAME   = CODE_MAX64 * CODE_MAX64 * 64'(MAX_PIXELS);
    localparam logic [63:0] SUM_WMAX   = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] SQ_WMAX    = (64'd1 << SQ_W) - 64'd1;
    localparam logic [63:0] CNT_WMAX   = (64'd1 << CNT_W) - 64'd1;
    localparam logic [63:0] SUM_CAP64  = (SUM_FRAME < SUM_WMAX) ? SUM_FRAME : SUM_WMAX;
    localparam logic [63:0] SQ_CAP64   = (SQ_FRAME < SQ_WMAX) ? SQ_FRAME : SQ_WMAX;
    localparam logic [63:0] CNT_CAP64  = (64'(MAX_PIXELS) < CNT_WMAX) ?
                                         64'(MAX_PIXELS) : CNT_WMAX;
    localparam logic [SUM_W:0] SUM_CAP = SUM_CAP64[SUM_W:0];
    localparam logic [SQ_W:0]  SQ_CAP  = SQ_CAP64[SQ_W:0];
    localparam logic [CNT_W:0] CNT_CAP = CNT_CAP64[CNT_W:0];
    localparam logic [VALUE_BITS-1:0] CODE_MAX_V = '1;

    logic [SUM_W-1:0] r_fp, r_fn, r_tp, r_tn;
    logic [SUM_W-1:0] n_fp, n_fn, n_tp, n_tn;
    logic [SQ_W-1:0]  r_sq, n_sq;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [SUM_W-1:0] r_tot_fp, r_tot_fn, r_tot_tp, r_tot_tn;
    logic [SQ_W-1:0]  r_tot_sq;
    logic [CNT_W-1:0] r_tot_cnt;
    logic [CODE_W-1:0] r_last_red, r_last_blue;

    logic              r_out_valid;
    logic              r_out_tv;
    logic [CODE_W-1:0] r_out_red, r_out_blue;
    logic [SUM_W-1:0]  r_out_fp, r_out_fn, r_out_tp, r_out_tn;
    logic [RMSE_W-1:0] r_out_rmse;
    logic [CNT_W-1:0]  r_out_cnt;

    logic [PW-1:0]         p, t, d;
    logic [2*PW-1:0]       d_sq;
    logic [VALUE_BITS-1:0] inv;
    logic                  neg;
    logic [SUM_W:0]        s_p_fp, s_inv_tn, s_p_tp, s_inv_fn;
    logic [SQ_W:0]         s_sq;
    logic [CNT_W:0]        s_cnt;
    logic [CODE_W-1:0]     red, blue;

    logic              div_done, sqrt_done;
    logic [NUM_W-1:0]  quotient;
    logic [ROOT_W-1:0] root;
    logic [RMSE_W-1:0] rmse;

    always_comb begin
        p    = i_predicted[PW-1:0];
        t    = i_truth[PW-1:0];
        d    = (p > t) ? (p - t) : (t - p);
        d_sq = (2*PW)'(d) * (2*PW)'(d);
        inv  = CODE_MAX_V - VALUE_BITS'(p);
        neg  = (t == '0);

        s_p_fp   = {1'b0, r_fp} + (SUM_W+1)'(p);
        s_inv_tn = {1'b0, r_tn} + (SUM_W+1)'(inv);
        s_p_tp   = {1'b0, r_tp} + (SUM_W+1)'(p);
        s_inv_fn = {1'b0, r_fn} + (SUM_W+1)'(inv);
        s_sq     = {1'b0, r_sq} + (SQ_W+1)'(d_sq);
        s_cnt    = {1'b0, r_cnt} + (CNT_W+1)'(1);

        n_fp = r_fp;
        n_fn = r_fn;
        n_tp = r_tp;
        n_tn = r_tn;
        n_sq = r_sq;
        n_cnt = r_cnt;
        red  = '0;
        blue = '0;
        if (i_region) begin
            n_sq  = (s_sq > SQ_CAP) ? SQ_CAP[SQ_W-1:0] : s_sq[SQ_W-1:0];
            n_cnt = (s_cnt > CNT_CAP) ? CNT_CAP[CNT_W-1:0] : s_cnt[CNT_W-1:0];
            if (neg) begin
                n_fp = (s_p_fp > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : s_p_fp[SUM_W-1:0];
                n_tn = (s_inv_tn > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : s_inv_tn[SUM_W-1:0];
                red  = CODE_W'(p);
            end else begin
                n_tp = (s_p_tp > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : s_p_tp[SUM_W-1:0];
                n_fn = (s_inv_fn > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : s_inv_fn[SUM_W-1:0];
                blue = CODE_W'(inv);
            end
        end
    end

    // accumulators, cleared once the frame's totals are captured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp  <= '0;
            r_fn  <= '0;
            r_tp  <= '0;
            r_tn  <= '0;
            r_sq  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.take_last) begin
            r_fp  <= '0;
            r_fn  <= '0;
            r_tp  <= '0;
            r_tn  <= '0;
            r_sq  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.take) begin
            r_fp  <= n_fp;
            r_fn  <= n_fn;
            r_tp  <= n_tp;
            r_tn  <= n_tn;
            r_sq  <= n_sq;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_last) begin
            r_tot_fp    <= n_fp;
            r_tot_fn    <= n_fn;
            r_tot_tp    <= n_tp;
            r_tot_tn    <= n_tn;
            r_tot_sq    <= n_sq;
            r_tot_cnt   <= n_cnt;
            r_last_red  <= red;
            r_last_blue <= blue;
        end
    end

    msc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_tot_sq, {FRAC_SH{1'b0}}}),
        .i_divisor  (r_tot_cnt),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    msc_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (quotient),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    always_comb begin
        if (r_tot_cnt == '0) begin
            rmse = '0;
        end else if (root[ROOT_W-1:RMSE_W] != '0) begin
            rmse = '1;
        end else begin
            rmse = root[RMSE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.take && !i_cmd.take_last) || i_cmd.load_totals) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && !i_cmd.take_last) begin
            r_out_tv   <= 1'b0;
            r_out_red  <= red;
            r_out_blue <= blue;
            r_out_fp   <= '0;
            r_out_fn   <= '0;
            r_out_tp   <= '0;
            r_out_tn   <= '0;
            r_out_rmse <= '0;
            r_out_cnt  <= '0;
        end else if (i_cmd.load_totals) begin
            r_out_tv   <= 1'b1;
            r_out_red  <= r_last_red;
            r_out_blue <= r_last_blue;
            r_out_fp   <= r_tot_fp;
            r_out_fn   <= r_tot_fn;
            r_out_tp   <= r_tot_tp;
            r_out_tn   <= r_tot_tn;
            r_out_rmse <= rmse;
            r_out_cnt  <= r_tot_cnt;
        end
    end

    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_status.div_done  = div_done;
    assign o_status.sqrt_done = sqrt_done;

    assign o_out_valid      = r_out_valid;
    assign o_totals_valid   = r_out_tv;
    assign o_diff_red       = r_out_red;
    assign o_diff_blue      = r_out_blue;
    assign o_sum_false_pos  = r_out_fp;
    assign o_sum_false_neg  = r_out_fn;
    assign o_sum_true_pos   = r_out_tp;
    assign o_sum_true_neg   = r_out_tn;
    assign o_rmse_value     = r_out_rmse;
    assign o_pixels_counted = r_out_cnt;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for masked_soft_confusion_rmse. Frames of pixels go in
// through the slave stream and every master beat is checked field by field
// against an in-bench scoring model. The model keeps its own copy of the soft
// confusion sums, the squared error and the pixel count. Both stream sides
// idle in random bursts, and one long master stall fills the block up. The
// last part of the run streams back to back with no idling.
// ----------------------------------------------------------------------------
module tb_top;
    import msc_pkg::*;

    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES = 120;
    localparam longint unsigned CODE_TOP = 64'd255;
    localparam longint unsigned SUM_CAP = 64'd267386880;
    localparam longint unsigned SQ_CAP = 64'd68182835200;
    localparam longint unsigned CNT_CAP = 64'd1048576;

    typedef struct {
        logic [CODE_W-1:0] red;
        logic [CODE_W-1:0] blue;
        logic              totals;
        logic [SUM_W-1:0]  false_pos;
        logic [SUM_W-1:0]  false_neg;
        logic [SUM_W-1:0]  true_pos;
        logic [SUM_W-1:0]  true_neg;
        logic [RMSE_W-1:0] rmse;
        logic [CNT_W-1:0]  count;
    } t_pix_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // predicted [7:0], truth [15:8]
    logic [IN_DW-1:0]  s_tdata = '0;
    // region_valid [0]
    logic              s_tuser = 1'b0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // diff_red [7:0], diff_blue [15:8], sum_false_pos [43:16],
    // sum_false_neg [71:44], sum_true_pos [99:72], sum_true_neg [127:100],
    // rmse_value [143:128], pixels_counted [164:144], zero [167:165]
    logic [OUT_DW-1:0] m_tdata;
    // totals_valid
    logic              m_tlast;

    longint unsigned acc_fp = 0;
    longint unsigned acc_fn = 0;
    longint unsigned acc_tp = 0;
    longint unsigned acc_tn = 0;
    longint unsigned acc_sq = 0;
    longint unsigned acc_count = 0;

    t_pix_result expected_beats[$];
    t_pix_result head_beat;
    int          mismatches = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    int          sink_wait = 0;
    int          holds_asked = 0;
    int          holds_done = 0;

    masked_soft_confusion_rmse dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint unsigned sat_sum(longint unsigned acc, longint unsigned add,
                                                longint unsigned cap);
        return (acc >= cap || add > cap - acc) ? cap : acc + add;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) root = trial;
        end
        return root;
    endfunction

    function automatic t_pix_result score_pixel(bit region, logic [7:0] pred,
                                                logic [7:0] truth, bit last);
        t_pix_result r;
        longint unsigned diff;
        longint unsigned q;
        r = '{default: '0};
        if (region) begin
            diff = (pred > truth) ? 64'(pred - truth) : 64'(truth - pred);
            acc_sq = sat_sum(acc_sq, diff * diff, SQ_CAP);
            acc_count = sat_sum(acc_count, 1, CNT_CAP);
            if (truth == 0) begin
                acc_fp = sat_sum(acc_fp, 64'(pred), SUM_CAP);
                acc_tn = sat_sum(acc_tn, CODE_TOP - 64'(pred), SUM_CAP);
                r.red = pred;
            end else begin
                acc_tp = sat_sum(acc_tp, 64'(pred), SUM_CAP);
                acc_fn = sat_sum(acc_fn, CODE_TOP - 64'(pred), SUM_CAP);
                r.blue = CODE_W'(CODE_TOP - 64'(pred));
            end
        end
        if (last) begin
            r.totals = 1'b1;
            r.false_pos = SUM_W'(acc_fp);
            r.false_neg = SUM_W'(acc_fn);
            r.true_pos = SUM_W'(acc_tp);
            r.true_neg = SUM_W'(acc_tn);
            r.count = CNT_W'(acc_count);
            if (acc_count != 0) begin
                q = floor_sqrt((acc_sq << 16) / acc_count);
                r.rmse = (q > 64'hffff) ? 16'hffff : RMSE_W'(q);
            end
            acc_fp = 0;
            acc_fn = 0;
            acc_tp = 0;
            acc_tn = 0;
            acc_sq = 0;
            acc_count = 0;
        end
        return r;
    endfunction

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat: tdata %h, tlast %b", m_tdata, m_tlast);
            end else begin
                head_beat = expected_beats.pop_front();
                check_field("diff_red", 64'(head_beat.red), 64'(m_tdata[7:0]));
                check_field("diff_blue", 64'(head_beat.blue), 64'(m_tdata[15:8]));
                check_field("totals_valid", 64'(head_beat.totals), 64'(m_tlast));
                check_field("sum_false_pos", 64'(head_beat.false_pos),
                            64'(m_tdata[43:16]));
                check_field("sum_false_neg", 64'(head_beat.false_neg),
                            64'(m_tdata[71:44]));
                check_field("sum_true_pos", 64'(head_beat.true_pos),
                            64'(m_tdata[99:72]));
                check_field("sum_true_neg", 64'(head_beat.true_neg),
                            64'(m_tdata[127:100]));
                check_field("rmse_value", 64'(head_beat.rmse), 64'(m_tdata[143:128]));
                check_field("pixels_counted", 64'(head_beat.count),
                            64'(m_tdata[164:144]));
                check_field("tdata padding", 64'd0, 64'(m_tdata[167:165]));
            end
        end
    end

    // master side ready: random stall bursts plus one long requested hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (sink_wait != 0) begin
            m_tready <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else if (holds_asked != holds_done) begin
            m_tready <= 1'b0;
            sink_wait <= HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            sink_wait <= $urandom_range(0, 18);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_pixel(input bit region, input logic [7:0] pred,
                              input logic [7:0] truth, input bit last);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {truth, pred};
        s_tuser <= region;
        s_tlast <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        expected_beats.push_back(score_pixel(region, pred, truth, last));
    endtask

    task automatic send_random_frame(input int len, input int inside_pct);
        logic [7:0] pred;
        logic [7:0] truth;
        bit         region;
        for (int k = 0; k < len; k++) begin
            region = ($urandom_range(0, 99) < inside_pct);
            case ($urandom_range(0, 7))
                0: pred = 8'h00;
                1: pred = 8'hff;
                default: pred = 8'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0, 1: truth = 8'h00;
                2: truth = 8'hff;
                default: truth = 8'($urandom);
            endcase
            send_pixel(region, pred, truth, k == len - 1);
        end
    endtask

    task automatic test_directed();
        // two pixels outside the region, making an empty frame
        send_pixel(1'b0, 8'hff, 8'h00, 1'b0);
        send_pixel(1'b0, 8'h12, 8'h34, 1'b1);
        // code extremes on both classes, frame closed by an outside pixel
        send_pixel(1'b1, 8'h00, 8'h00, 1'b0);
        send_pixel(1'b1, 8'hff, 8'h00, 1'b0);
        send_pixel(1'b1, 8'h00, 8'hff, 1'b0);
        send_pixel(1'b1, 8'hff, 8'hff, 1'b0);
        send_pixel(1'b1, 8'hff, 8'h01, 1'b0);
        send_pixel(1'b1, 8'h00, 8'h01, 1'b0);
        send_pixel(1'b1, 8'h80, 8'h00, 1'b0);
        send_pixel(1'b0, 8'hff, 8'hff, 1'b1);
        // single pixel frame with the largest error
        send_pixel(1'b1, 8'hff, 8'h00, 1'b1);
        // alternating bit patterns
        send_pixel(1'b1, 8'haa, 8'h55, 1'b0);
        send_pixel(1'b1, 8'h55, 8'haa, 1'b0);
        send_pixel(1'b0, 8'haa, 8'h55, 1'b0);
        send_pixel(1'b1, 8'h01, 8'hfe, 1'b1);
    endtask

    task automatic test_random_frames(input int pixels);
        int sent;
        int len;
        int pct;
        sent = 0;
        while (sent < pixels) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
            case ($urandom_range(0, 5))
                0: pct = 10;
                1: pct = 100;
                default: pct = 85;
            endcase
            send_random_frame(len, pct);
            sent += len;
        end
    endtask

    task automatic test_output_backpressure();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        holds_asked++;
        send_random_frame(30, 90);
        send_random_frame(10, 100);
    endtask

    task automatic test_steady_stream();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        send_random_frame(1, 100);
        send_random_frame(50, 100);
        send_random_frame(29, 80);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_frames(300);
        test_output_backpressure();
        test_steady_stream();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
